FILE: hdl/env_sensor_compensation_top_macros.svh
// Assertion macros used by the compensation block checker.
`ifndef ENV_SENSOR_COMPENSATION_TOP_MACROS_SVH
`define ENV_SENSOR_COMPENSATION_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ESC_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("esc check failed");

// Property that must hold on every result beat.
`define ESC_ON_DONE(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) done |-> (prop)) \
    else $error("esc result check failed");

`endif

FILE: hdl/esc_pkg.sv
// Types, constants and arithmetic helpers for the sensor compensation block.
`default_nettype none
package esc_pkg;

  typedef logic [31:0] word_t;

  // Configuration port geometry
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  typedef enum logic [2:0] {
    REG_TEMP_CALIB,
    REG_PRESS_A,
    REG_PRESS_B,
    REG_PRESS_C,
    REG_HUM_CALIB
  } reg_idx_t;

  // Pipeline depths
  localparam int TEMP_LAT  = 3;
  localparam int FRONT_LAT = 6;
  localparam int DIV_STEPS = 32;
  localparam int BACK_LAT  = 3;
  localparam int SIDE_LAT  = 8;
  localparam int LATENCY   = TEMP_LAT + FRONT_LAT + DIV_STEPS + BACK_LAT;
  localparam int SIDE_DELAY = LATENCY - TEMP_LAT - SIDE_LAT;

  // Compensation constants
  localparam word_t K_64000    = 32'd64000;
  localparam word_t K_1048576  = 32'd1048576;
  localparam word_t K_3125     = 32'd3125;
  localparam word_t K_76800    = 32'd76800;
  localparam word_t K_HUM_MAX  = 32'd419430400;
  localparam word_t K_2097152  = 32'd2097152;
  localparam word_t K_16384    = 32'd16384;
  localparam word_t K_32768    = 32'd32768;
  localparam word_t K_8192     = 32'd8192;
  localparam word_t K_128      = 32'd128;
  localparam word_t K_5        = 32'd5;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] fine_temperature;
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_pa;
    logic               pressure_valid;
    logic [16:0]        humidity_q10;
  } out_item_t;

  // Calibration coefficients, each widened to a 32-bit word
  typedef struct packed {
    word_t t1, t2, t3;
    word_t p1, p2, p3, p4, p5, p6, p7, p8, p9;
    word_t h1, h2, h3, h4, h5, h6;
  } coef_t;

  // Temperature and humidity results waiting for the pressure path
  typedef struct packed {
    word_t       fine;
    word_t       centi;
    logic [16:0] hum;
  } side_t;

  // Flags that ride along with the divider
  typedef struct packed {
    logic post2;
    logic zero;
  } div_side_t;

  function automatic word_t asr(word_t x, int unsigned n);
    return word_t'($signed(x) >>> n);
  endfunction

  function automatic word_t mul(word_t a, word_t b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  function automatic word_t sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic word_t sx12(logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

  function automatic word_t sx8(logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

endpackage
`default_nettype wire

FILE: hdl/esc_regs.sv
// Calibration register file behind the APB-style port, with coefficient decode.
`default_nettype none
module esc_regs (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [esc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [esc_pkg::DATA_W-1:0] pwdata,
  output      logic [esc_pkg::DATA_W-1:0] prdata,
  output      logic                      pready,
  output      esc_pkg::coef_t            coef
);
  import esc_pkg::*;

  logic [47:0] temp_calib;
  logic [63:0] press_calib_a;
  logic [63:0] press_calib_b;
  logic [15:0] press_calib_c;
  logic [63:0] hum_calib;
  reg_idx_t    idx;
  logic        wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[5:3]);
  assign wr     = psel & penable & pwrite;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib    <= '0;
      press_calib_a <= '0;
      press_calib_b <= '0;
      press_calib_c <= '0;
      hum_calib     <= '0;
    end else if (wr) begin
      case (idx)
        REG_TEMP_CALIB: temp_calib    <= pwdata[47:0];
        REG_PRESS_A:    press_calib_a <= pwdata;
        REG_PRESS_B:    press_calib_b <= pwdata;
        REG_PRESS_C:    press_calib_c <= pwdata[15:0];
        REG_HUM_CALIB:  hum_calib     <= pwdata;
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_TEMP_CALIB: prdata = {16'b0, temp_calib};
      REG_PRESS_A:    prdata = press_calib_a;
      REG_PRESS_B:    prdata = press_calib_b;
      REG_PRESS_C:    prdata = {48'b0, press_calib_c};
      REG_HUM_CALIB:  prdata = hum_calib;
      default:        prdata = '0;
    endcase
  end

  // Field unpacking
  always_comb begin
    coef.t1 = {16'b0, temp_calib[15:0]};
    coef.t2 = sx16(temp_calib[31:16]);
    coef.t3 = sx16(temp_calib[47:32]);
    coef.p1 = {16'b0, press_calib_a[15:0]};
    coef.p2 = sx16(press_calib_a[31:16]);
    coef.p3 = sx16(press_calib_a[47:32]);
    coef.p4 = sx16(press_calib_a[63:48]);
    coef.p5 = sx16(press_calib_b[15:0]);
    coef.p6 = sx16(press_calib_b[31:16]);
    coef.p7 = sx16(press_calib_b[47:32]);
    coef.p8 = sx16(press_calib_b[63:48]);
    coef.p9 = sx16(press_calib_c);
    coef.h1 = {24'b0, hum_calib[7:0]};
    coef.h2 = sx16(hum_calib[23:8]);
    coef.h3 = {24'b0, hum_calib[31:24]};
    coef.h4 = sx12(hum_calib[43:32]);
    coef.h5 = sx12(hum_calib[55:44]);
    coef.h6 = sx8(hum_calib[63:56]);
  end

endmodule
`default_nettype wire

FILE: hdl/esc_temp.sv
// Fine temperature pipeline, three stages; carries the other raw readings along.
`default_nettype none
module esc_temp (
  input  wire logic              clk,
  input  wire esc_pkg::in_item_t item,
  input  wire esc_pkg::coef_t    coef,
  output      esc_pkg::word_t    tfine,
  output      esc_pkg::in_item_t item_d
);
  import esc_pkg::*;

  word_t    adc, d;
  word_t    s1_m1, s1_m2, s2_v1, s2_m3;
  in_item_t s1_item, s2_item;

  assign adc = {12'b0, item.raw_temperature};
  assign d   = (adc >> 4) - coef.t1;

  always_ff @(posedge clk) begin
    // stage 1: both first products
    s1_m1   <= mul((adc >> 3) - (coef.t1 << 1), coef.t2);
    s1_m2   <= mul(d, d);
    s1_item <= item;
    // stage 2: T3 term
    s2_v1   <= asr(s1_m1, 11);
    s2_m3   <= mul(asr(s1_m2, 12), coef.t3);
    s2_item <= s1_item;
    // stage 3: sum
    tfine   <= s2_v1 + asr(s2_m3, 14);
    item_d  <= s2_item;
  end

endmodule
`default_nettype wire

FILE: hdl/esc_side.sv
// Humidity pipeline, eight stages; also forms centi-degrees and carries the fine value.
`default_nettype none
module esc_side (
  input  wire logic           clk,
  input  wire esc_pkg::word_t tfine,
  input  wire logic [15:0]    raw_humidity,
  input  wire esc_pkg::coef_t coef,
  output      esc_pkg::side_t side
);
  import esc_pkg::*;

  word_t hh, h, r4_e;
  word_t r1_mh5, r1_mh6, r1_mh3;
  logic [15:0] r1_adc;
  word_t r2_a, r2_b, r2_c;
  word_t r3_mbc, r3_a;
  word_t r4_me, r4_a;
  word_t r5_hm;
  word_t r6_sq, r6_hm;
  word_t r7_mh1, r7_hm;
  logic [16:0] hum_q;
  word_t fine_q  [SIDE_LAT];
  word_t centi_q [SIDE_LAT];

  assign hh   = tfine - K_76800;
  assign r4_e = asr(r3_mbc, 10) + K_2097152;

  // Final subtract and clamp to 0..100 percent
  always_comb begin
    h = r7_hm - asr(r7_mh1, 4);
    if (h[31])
      h = '0;
    if (h > K_HUM_MAX)
      h = K_HUM_MAX;
  end

  always_ff @(posedge clk) begin
    // stage 1: products of the temperature offset
    r1_mh5 <= mul(coef.h5, hh);
    r1_mh6 <= mul(hh, coef.h6);
    r1_mh3 <= mul(hh, coef.h3);
    r1_adc <= raw_humidity;
    // stage 2: the three factors
    r2_a <= asr(({16'b0, r1_adc} << 14) - (coef.h4 << 20) - r1_mh5 + K_16384, 15);
    r2_b <= asr(r1_mh6, 10);
    r2_c <= asr(r1_mh3, 11) + K_32768;
    // stage 3
    r3_mbc <= mul(r2_b, r2_c);
    r3_a   <= r2_a;
    // stage 4
    r4_me <= mul(r4_e, coef.h2);
    r4_a  <= r3_a;
    // stage 5
    r5_hm <= mul(r4_a, asr(r4_me + K_8192, 14));
    // stage 6
    r6_sq <= mul(asr(r5_hm, 15), asr(r5_hm, 15));
    r6_hm <= r5_hm;
    // stage 7
    r7_mh1 <= mul(asr(r6_sq, 7), coef.h1);
    r7_hm  <= r6_hm;
    // stage 8
    hum_q <= h[28:12];
  end

  // Fine temperature and centi-degrees travel alongside
  always_ff @(posedge clk) begin
    fine_q[0]  <= tfine;
    centi_q[0] <= asr(mul(tfine, K_5) + K_128, 8);
    for (int i = 1; i < SIDE_LAT; i++) begin
      fine_q[i]  <= fine_q[i-1];
      centi_q[i] <= centi_q[i-1];
    end
  end

  always_comb begin
    side.fine  = fine_q[SIDE_LAT-1];
    side.centi = centi_q[SIDE_LAT-1];
    side.hum   = hum_q;
  end

endmodule
`default_nettype wire

FILE: hdl/esc_pfront.sv
// Pressure front end, six stages: forms the dividend and divisor.
`default_nettype none
module esc_pfront (
  input  wire logic               clk,
  input  wire esc_pkg::word_t     tfine,
  input  wire logic [19:0]        raw_pressure,
  input  wire esc_pkg::coef_t     coef,
  output      esc_pkg::word_t     dividend,
  output      esc_pkg::word_t     divisor,
  output      esc_pkg::div_side_t dside
);
  import esc_pkg::*;

  word_t pv1, q;
  word_t f1_sq, f1_mp5, f1_mp2;
  word_t f2_v2a, f2_mp3, f2_mp5, f2_mp2;
  word_t f3_v2, f3_v1;
  word_t f4_mp1, f4_nsub;
  word_t f5_div, f5_num;
  logic [19:0] f1_adc, f2_adc, f3_adc;

  assign pv1 = asr(tfine, 1) - K_64000;
  assign q   = asr(pv1, 2);

  always_ff @(posedge clk) begin
    // stage 1
    f1_sq  <= mul(q, q);
    f1_mp5 <= mul(pv1, coef.p5);
    f1_mp2 <= mul(coef.p2, pv1);
    f1_adc <= raw_pressure;
    // stage 2
    f2_v2a <= mul(asr(f1_sq, 11), coef.p6);
    f2_mp3 <= mul(coef.p3, asr(f1_sq, 13));
    f2_mp5 <= f1_mp5;
    f2_mp2 <= f1_mp2;
    f2_adc <= f1_adc;
    // stage 3
    f3_v2  <= asr(f2_v2a + (f2_mp5 << 1), 2) + (coef.p4 << 16);
    f3_v1  <= asr(asr(f2_mp3, 3) + asr(f2_mp2, 1), 18);
    f3_adc <= f2_adc;
    // stage 4
    f4_mp1  <= mul(K_32768 + f3_v1, coef.p1);
    f4_nsub <= (K_1048576 - {12'b0, f3_adc}) - asr(f3_v2, 12);
    // stage 5
    f5_div <= asr(f4_mp1, 15);
    f5_num <= mul(f4_nsub, K_3125);
    // stage 6: pre-doubling when it cannot overflow
    divisor     <= f5_div;
    dividend    <= f5_num[31] ? f5_num : (f5_num << 1);
    dside.post2 <= f5_num[31];
    dside.zero  <= (f5_div == '0);
  end

endmodule
`default_nettype wire

FILE: hdl/esc_div.sv
// Unsigned 32/32 restoring divider, one quotient bit per pipeline stage.
`default_nettype none
module esc_div (
  input  wire logic               clk,
  input  wire esc_pkg::word_t     dividend,
  input  wire esc_pkg::word_t     divisor,
  input  wire esc_pkg::div_side_t side_in,
  output      esc_pkg::word_t     quotient,
  output      esc_pkg::div_side_t side_out
);
  import esc_pkg::*;

  word_t     rem_q  [DIV_STEPS];
  word_t     wq_q   [DIV_STEPS];
  word_t     dvs_q  [DIV_STEPS];
  div_side_t side_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    word_t       r_in, w_in, d_in;
    div_side_t   s_in;
    logic [32:0] trial, diff;
    logic        ge;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign w_in = dividend;
      assign d_in = divisor;
      assign s_in = side_in;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign w_in = wq_q[k-1];
      assign d_in = dvs_q[k-1];
      assign s_in = side_q[k-1];
    end

    // shift in next dividend bit, trial subtract
    assign trial = {r_in, w_in[31]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = (trial >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      rem_q[k]  <= ge ? diff[31:0] : trial[31:0];
      wq_q[k]   <= {w_in[30:0], ge};
      dvs_q[k]  <= d_in;
      side_q[k] <= s_in;
    end
  end

  assign quotient = wq_q[DIV_STEPS-1];
  assign side_out = side_q[DIV_STEPS-1];

endmodule
`default_nettype wire

FILE: hdl/esc_pback.sv
// Pressure back end, three stages: undoes pre-doubling and applies P7..P9.
`default_nettype none
module esc_pback (
  input  wire logic               clk,
  input  wire esc_pkg::word_t     quotient,
  input  wire esc_pkg::div_side_t side_in,
  input  wire esc_pkg::coef_t     coef,
  output      logic [31:0]        pressure_pa,
  output      logic               pressure_valid
);
  import esc_pkg::*;

  word_t     p;
  word_t     b1_m9a, b1_m8, b1_p;
  word_t     b2_m9, b2_m8s, b2_p;
  div_side_t b1_side, b2_side;

  assign p = side_in.post2 ? (quotient << 1) : quotient;

  always_ff @(posedge clk) begin
    // stage 1
    b1_m9a  <= mul(p >> 3, p >> 3);
    b1_m8   <= mul(p >> 2, coef.p8);
    b1_p    <= p;
    b1_side <= side_in;
    // stage 2
    b2_m9   <= mul(coef.p9, b1_m9a >> 13);
    b2_m8s  <= asr(b1_m8, 13);
    b2_p    <= b1_p;
    b2_side <= b1_side;
    // stage 3: correction, zero divisor forces invalid
    pressure_pa    <= b2_side.zero ? '0 : b2_p + asr(asr(b2_m9, 12) + b2_m8s + coef.p7, 4);
    pressure_valid <= ~b2_side.zero;
  end

endmodule
`default_nettype wire

FILE: hdl/env_sensor_compensation_top.sv
// Top level of the environmental sensor integer compensation pipeline.
//
//  channel   direction  handshake               payload
//  input     in         start (busy stays low)  in_item  (in_item_t)
//  result    out        done strobe, 1 cycle    result   (out_item_t)
//  config    in/out     APB-style, pready = 1   paddr/pwdata/prdata, 64-bit
//
// One item enters per cycle; each result follows its start through the temperature
// stages, the pressure front end, the 32-stage pipelined divider and the back end.
// Reset clears the calibration registers and the valid chain; data stages
// are not reset. The receiver cannot stall, so nothing ever holds the pipe.
`default_nettype none
module env_sensor_compensation_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output      logic                      busy,
  input  wire esc_pkg::in_item_t         in_item,
  output      logic                      done,
  output      esc_pkg::out_item_t        result,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [esc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [esc_pkg::DATA_W-1:0] pwdata,
  output      logic [esc_pkg::DATA_W-1:0] prdata,
  output      logic                      pready
);
  import esc_pkg::*;

  coef_t       coef;
  word_t       tfine, dividend, divisor, quotient;
  in_item_t    item_d;
  div_side_t   dside, qside;
  side_t       side;
  side_t       side_q [SIDE_DELAY];
  logic [31:0] pressure_pa;
  logic        pressure_valid;
  logic [LATENCY-1:0] vld;

  assign busy = 1'b0;

  esc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .coef
  );

  esc_temp u_temp (
    .clk, .item(in_item), .coef, .tfine, .item_d
  );

  esc_side u_side (
    .clk, .tfine, .raw_humidity(item_d.raw_humidity), .coef, .side
  );

  esc_pfront u_pfront (
    .clk, .tfine, .raw_pressure(item_d.raw_pressure), .coef,
    .dividend, .divisor, .dside
  );

  esc_div u_div (
    .clk, .dividend, .divisor, .side_in(dside), .quotient, .side_out(qside)
  );

  esc_pback u_pback (
    .clk, .quotient, .side_in(qside), .coef, .pressure_pa, .pressure_valid
  );

  // Temperature/humidity wait for the pressure path
  always_ff @(posedge clk) begin
    side_q[0] <= side;
    for (int i = 1; i < SIDE_DELAY; i++)
      side_q[i] <= side_q[i-1];
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start & ~busy};
    end
  end

  assign done = vld[LATENCY-1];

  always_comb begin
    result.fine_temperature  = side_q[SIDE_DELAY-1].fine;
    result.temperature_centi = side_q[SIDE_DELAY-1].centi;
    result.pressure_pa       = pressure_pa;
    result.pressure_valid    = pressure_valid;
    result.humidity_q10      = side_q[SIDE_DELAY-1].hum;
  end

endmodule
`default_nettype wire

FILE: hdl/esc_checker.sv
// Port-level checks for the compensation block, bound to the top level.
`default_nettype none
`include "env_sensor_compensation_top_macros.svh"
module esc_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               done,
  input wire esc_pkg::out_item_t result,
  input wire logic               pready
);
  import esc_pkg::*;

  // each result beat comes from a start beat a fixed latency earlier
  `ESC_ALWAYS(a_done_from_start, done |-> $past(start && !busy, LATENCY))
  // invalid pressure reads as zero
  `ESC_ON_DONE(a_press_invalid_zero, result.pressure_valid || result.pressure_pa == 32'd0)
  // humidity stays within 0..100 percent
  `ESC_ON_DONE(a_hum_range, result.humidity_q10 <= 17'd102400)
  `ESC_ALWAYS(a_pready_high, pready)

endmodule

bind env_sensor_compensation_top esc_checker u_esc_checker (.*);
`default_nettype wire

FILE: tb/sv/tb_env_sensor_compensation_top.sv
// Self-checking testbench for the environmental sensor compensation pipeline.
`default_nettype none
module tb_env_sensor_compensation_top;
  timeunit 1ns;
  timeprecision 1ps;
  import esc_pkg::*;

  localparam int PIPE_DEPTH  = 44;
  localparam int STALL_LIMIT = 20000;
  localparam int IDLE_PCT    = 38;
  // Compensation constants kept as signed words for the predictor
  localparam int C_64000   = 64000;
  localparam int C_1M      = 1048576;
  localparam int C_3125    = 3125;
  localparam int C_76800   = 76800;
  localparam int C_HUM_MAX = 419430400;
  localparam int C_2M      = 2097152;
  localparam int C_16384   = 16384;
  localparam int C_32768   = 32768;
  localparam int C_8192    = 8192;
  localparam int C_128     = 128;

  logic clk = 1'b0;
  logic rst, start, busy, done;
  in_item_t in_item;
  out_item_t result;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;

  env_sensor_compensation_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #10 clk = ~clk;

  // Calibration shadow, updated after each register write
  logic [47:0] cal_temp;
  logic [63:0] cal_press_a, cal_press_b, cal_hum;
  logic [15:0] cal_press_c;

  out_item_t pending_results[$];
  int n_items, n_results, n_errors, n_press_invalid, n_hum_clamped;
  int stall_cycles;
  bit gaps_on;
  logic busy_mid;

  // Mid-cycle sample of busy, stable at the next rising edge
  always @(negedge clk) busy_mid <= busy;

  // Integer compensation of one reading with the current calibration
  function automatic out_item_t compensate(in_item_t x);
    int t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    int h1, h2, h3, h4, h5, h6;
    int adc_t, adc_p, adc_h, v1, v2, d, tf, sq, h, a, b, c, e, f;
    int unsigned pu, q;
    out_item_t r;
    t1 = int'({16'b0, cal_temp[15:0]});
    t2 = int'($signed(cal_temp[31:16]));
    t3 = int'($signed(cal_temp[47:32]));
    p1 = int'({16'b0, cal_press_a[15:0]});
    p2 = int'($signed(cal_press_a[31:16]));
    p3 = int'($signed(cal_press_a[47:32]));
    p4 = int'($signed(cal_press_a[63:48]));
    p5 = int'($signed(cal_press_b[15:0]));
    p6 = int'($signed(cal_press_b[31:16]));
    p7 = int'($signed(cal_press_b[47:32]));
    p8 = int'($signed(cal_press_b[63:48]));
    p9 = int'($signed(cal_press_c));
    h1 = int'({24'b0, cal_hum[7:0]});
    h2 = int'($signed(cal_hum[23:8]));
    h3 = int'({24'b0, cal_hum[31:24]});
    h4 = int'($signed(cal_hum[43:32]));
    h5 = int'($signed(cal_hum[55:44]));
    h6 = int'($signed(cal_hum[63:56]));
    adc_t = int'({12'b0, x.raw_temperature});
    adc_p = int'({12'b0, x.raw_pressure});
    adc_h = int'({16'b0, x.raw_humidity});

    // temperature
    v1 = (((adc_t >>> 3) - (t1 <<< 1)) * t2) >>> 11;
    d  = (adc_t >>> 4) - t1;
    v2 = (((d * d) >>> 12) * t3) >>> 14;
    tf = v1 + v2;
    r.fine_temperature  = tf;
    r.temperature_centi = (tf * 5 + C_128) >>> 8;

    // pressure
    v1 = (tf >>> 1) - C_64000;
    sq = (v1 >>> 2) * (v1 >>> 2);
    v2 = (sq >>> 11) * p6;
    v2 = v2 + ((v1 * p5) <<< 1);
    v2 = (v2 >>> 2) + (p4 <<< 16);
    v1 = (((p3 * (sq >>> 13)) >>> 3) + ((p2 * v1) >>> 1)) >>> 18;
    v1 = ((C_32768 + v1) * p1) >>> 15;
    if (v1 == 0) begin
      r.pressure_pa = '0;
      r.pressure_valid = 1'b0;
    end else begin
      pu = int'((C_1M - adc_p) - (v2 >>> 12)) * C_3125;
      q = v1;
      if (pu < 32'h8000_0000) pu = (pu << 1) / q;
      else pu = (pu / q) * 2;
      q  = ((pu >> 3) * (pu >> 3)) >> 13;
      v1 = (p9 * int'(q)) >>> 12;
      v2 = (int'(pu >> 2) * p8) >>> 13;
      r.pressure_pa = pu + int'((v1 + v2 + p7) >>> 4);
      r.pressure_valid = 1'b1;
    end

    // humidity
    h = tf - C_76800;
    a = ((adc_h <<< 14) - (h4 <<< 20) - h5 * h + C_16384) >>> 15;
    b = (h * h6) >>> 10;
    c = ((h * h3) >>> 11) + C_32768;
    e = ((b * c) >>> 10) + C_2M;
    f = (e * h2 + C_8192) >>> 14;
    h = a * f;
    sq = (h >>> 15) * (h >>> 15);
    h = h - ((((sq >>> 7) * h1)) >>> 4);
    if (h < 0) h = 0;
    if (h > C_HUM_MAX) h = C_HUM_MAX;
    r.humidity_q10 = 17'(h >>> 12);
    return r;
  endfunction

  // Result checker: each done beat is matched against the oldest prediction
  always @(negedge clk) begin
    out_item_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no prediction waiting");
        n_errors++;
      end else begin
        exp_r = pending_results.pop_front();
        n_results++;
        if (!exp_r.pressure_valid) n_press_invalid++;
        if (exp_r.humidity_q10 == 17'd0 || exp_r.humidity_q10 == 17'd102400)
          n_hum_clamped++;
        if (result.fine_temperature !== exp_r.fine_temperature) begin
          $error("fine_temperature exp %0d got %0d",
                 exp_r.fine_temperature, result.fine_temperature);
          n_errors++;
        end
        if (result.temperature_centi !== exp_r.temperature_centi) begin
          $error("temperature_centi exp %0d got %0d",
                 exp_r.temperature_centi, result.temperature_centi);
          n_errors++;
        end
        if (result.pressure_pa !== exp_r.pressure_pa) begin
          $error("pressure_pa exp %0d got %0d", exp_r.pressure_pa, result.pressure_pa);
          n_errors++;
        end
        if (result.pressure_valid !== exp_r.pressure_valid) begin
          $error("pressure_valid exp %0b got %0b",
                 exp_r.pressure_valid, result.pressure_valid);
          n_errors++;
        end
        if (result.humidity_q10 !== exp_r.humidity_q10) begin
          $error("humidity_q10 exp %0d got %0d", exp_r.humidity_q10, result.humidity_q10);
          n_errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Register write over the APB-style port: setup phase, access phase, then back to idle
  task automatic cfg_write(reg_idx_t idx, logic [63:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(int'(idx) * 8); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TEMP_CALIB: cal_temp    = value[47:0];
      REG_PRESS_A:    cal_press_a = value;
      REG_PRESS_B:    cal_press_b = value;
      REG_PRESS_C:    cal_press_c = value[15:0];
      default:        cal_hum     = value;
    endcase
  endtask

  task automatic load_calib(logic [47:0] t, logic [63:0] pa, logic [63:0] pb,
                            logic [15:0] pc, logic [63:0] hc);
    cfg_write(REG_TEMP_CALIB, {16'b0, t});
    cfg_write(REG_PRESS_A, pa);
    cfg_write(REG_PRESS_B, pb);
    cfg_write(REG_PRESS_C, {48'b0, pc});
    cfg_write(REG_HUM_CALIB, hc);
  endtask

  // Typical sensor calibration
  task automatic load_typical();
    load_calib({16'(-1000), 16'(26435), 16'(27504)},
               {16'(2855), 16'(3024), 16'(-10685), 16'(36477)},
               {16'(-14600), 16'(15500), 16'(-7), 16'(140)},
               16'(6000),
               {8'(30), 12'(50), 12'(313), 8'(0), 16'(362), 8'(75)});
  endtask

  // Send one reading; start stays high across back-to-back beats
  task automatic send_reading(in_item_t x);
    if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      in_item <= in_item_t'(56'({$urandom, $urandom}));
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= x;
    @(posedge clk);
    while (busy_mid) @(posedge clk);
    pending_results.push_back(compensate(x));
    n_items++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  function automatic in_item_t reading(int t, int p, int h);
    in_item_t x;
    x.raw_temperature = 20'(t);
    x.raw_pressure = 20'(p);
    x.raw_humidity = 16'(h);
    return x;
  endfunction

  function automatic in_item_t rand_reading(bit plausible);
    if (plausible)
      return reading($urandom_range(400000, 600000), $urandom_range(250000, 450000),
                     $urandom_range(20000, 40000));
    return reading($urandom, $urandom, $urandom);
  endfunction

  // All calibration zero: pressure divisor is zero
  task automatic test_reset_calib();
    send_reading(reading(0, 0, 0));
    send_reading(reading(519888, 415148, 30000));
    send_reading(reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF));
    drain();
  endtask

  // Typical calibration with field extremes and humidity clamps
  task automatic test_typical_extremes();
    load_typical();
    send_reading(reading(519888, 415148, 30000));
    send_reading(reading(0, 0, 0));
    send_reading(reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF));
    send_reading(reading(519888, 0, 16'hFFFF));
    send_reading(reading(519888, 20'hFFFFF, 0));
    send_reading(reading(0, 415148, 65535));
    send_reading(reading(20'hFFFFF, 415148, 0));
    drain();
  endtask

  // Calibration extremes: all ones, sign bits only, max magnitudes
  task automatic test_calib_extremes();
    load_calib('1, '1, '1, '1, '1);
    send_reading(reading(519888, 415148, 30000));
    send_reading(reading(20'hFFFFF, 0, 16'hFFFF));
    drain();
    load_calib({16'h8000, 16'h8000, 16'h0000}, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
               {4{16'h8000}}, 16'h8000, 64'h80_800_800_FF_8000_FF);
    send_reading(reading(0, 0, 0));
    send_reading(reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF));
    drain();
    load_calib({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001},
               {4{16'h7FFF}}, 16'h7FFF, 64'h7F_7FF_7FF_00_7FFF_00);
    send_reading(reading(519888, 415148, 30000));
    send_reading(reading(0, 20'hFFFFF, 0));
    drain();
  endtask

  // Random readings under a mix of calibration sets
  task automatic test_random_phases();
    for (int ph = 0; ph < 6; ph++) begin
      gaps_on = (ph != 2);
      if (ph % 2 == 0) load_typical();
      else load_calib(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                      16'($urandom), {$urandom, $urandom});
      for (int i = 0; i < 300; i++)
        send_reading(rand_reading(ph % 2 == 0 && $urandom_range(3) != 0));
      drain();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst = 1'b1; start = 1'b0; in_item = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cal_temp = '0; cal_press_a = '0; cal_press_b = '0; cal_press_c = '0; cal_hum = '0;
    gaps_on = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_calib();
    test_typical_extremes();
    test_calib_extremes();
    test_random_phases();
    $display("Ran %0d readings, %0d results checked", n_items, n_results);
    $display("Covered reset, typical and extreme calibration sets (%0d without pressure, %0d at a humidity bound)",
             n_press_invalid, n_hum_clamped);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (pending_results.size() != 0) $error("%0d results never arrived", pending_results.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
